// File: rtl/skf_pkg.sv
// ----------------------------------------------------------------------------
// skf_pkg: shared types and constants of the scalar kalman filter
// register indexes, reset values, sequencer states and step counts
// ----------------------------------------------------------------------------
package skf_pkg;

   localparam int unsigned DATA_W  = 32;
   localparam int unsigned MEAS_W  = 16;
   localparam int unsigned GAIN_W  = 17;
   localparam int unsigned CNT_W   = 5;
   localparam int unsigned IDX_W   = 2;

   // one quotient or multiplier bit per cycle
   localparam logic [CNT_W-1:0] LAST_STEP = 5'd16;

   localparam logic [GAIN_W-1:0] GAIN_ONE = 17'h10000;

   localparam logic [IDX_W-1:0] REG_INIT_ESTIMATE = 2'd0;
   localparam logic [IDX_W-1:0] REG_INIT_VARIANCE = 2'd1;
   localparam logic [IDX_W-1:0] REG_PROCESS_NOISE = 2'd2;
   localparam logic [IDX_W-1:0] REG_MEASURE_NOISE = 2'd3;

   localparam logic [DATA_W-1:0] RST_INIT_ESTIMATE = 32'd0;
   localparam logic [DATA_W-1:0] RST_INIT_VARIANCE = 32'd65536;
   localparam logic [DATA_W-1:0] RST_PROCESS_NOISE = 32'd655;
   localparam logic [DATA_W-1:0] RST_MEASURE_NOISE = 32'd65536;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PRED,
      ST_DEN,
      ST_DIV,
      ST_MUL,
      ST_FIN
   } state_type;

endpackage

// File: rtl/scalar_kalman_filter_top.sv
// ----------------------------------------------------------------------------
// scalar_kalman_filter_top: one-dimensional kalman filter, a = h = 1
//
// req channel: one signed 16-bit measurement word per valid/ready handshake.
// rsp channel: one signed q16.16 filtered estimate word per request.
// csr port: plain write port, index 0 initial estimate, 1 initial variance,
// 2 process noise, 3 measurement noise. writes to 0 or 1 reload the state.
// write csr only while no request is in flight.
// each request runs through prediction and the denominator, then the
// bit-serial restoring divider for the gain, then the bit-serial shift-add
// multipliers for correction and variance, then writeback. one request is
// worked on at a time; the next one can be taken once the response is
// loaded into the output register.
// req_ready is high only while the sequencer is idle.
// the response sits in an output register; a stalled receiver holds the
// finished result in writeback until the output register frees up.
// reset: synchronous, active high; csr return to their reset values, the
// estimate and variance load from them, no response is pending.
// ----------------------------------------------------------------------------
module scalar_kalman_filter_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic signed [skf_pkg::MEAS_W-1:0] req_measurement,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [skf_pkg::DATA_W-1:0] rsp_filtered_estimate,
   input  logic                              csr_wr_en,
   input  logic        [skf_pkg::IDX_W-1:0]  csr_index,
   input  logic        [skf_pkg::DATA_W-1:0] csr_wdata
);
   import skf_pkg::*;

   state_type state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   logic [DATA_W-1:0] init_est_ff, init_est_in;
   logic [DATA_W-1:0] init_var_ff, init_var_in;
   logic [DATA_W-1:0] q_ff, q_in;
   logic [DATA_W-1:0] r_ff, r_in;

   logic [DATA_W-1:0] est_ff, est_in;
   logic [DATA_W-1:0] var_ff, var_in;

   logic signed [33:0] res_ff, res_in;
   logic [DATA_W-1:0] p_ff, p_in;
   logic [DATA_W-1:0] den_ff, den_in;
   logic              den_zero_ff, den_zero_in;
   logic [DATA_W-1:0] rem_ff, rem_in;
   logic [GAIN_W-1:0] quo_ff, quo_in;
   logic [GAIN_W-1:0] ma_ff, ma_in;
   logic [GAIN_W-1:0] mb_ff, mb_in;
   logic signed [50:0] acc1_ff, acc1_in;
   logic [48:0] acc2_ff, acc2_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic [32:0] p_sum, den_sum, rem_sh, rem_diff;
   logic        div_bit, div_ge;
   logic signed [33:0] meas_q16, est_wide;
   logic signed [50:0] res_ext;
   logic [48:0] p_ext;
   logic [34:0] corr;
   logic [35:0] nx_sum;
   logic [DATA_W-1:0] nx_sat;
   logic        out_free;

   always_comb begin
      p_sum    = {1'b0, var_ff} + {1'b0, q_ff};
      den_sum  = {1'b0, p_ff} + {1'b0, r_ff};
      div_bit  = (cnt_ff == '0) ? p_ff[0] : 1'b0;
      rem_sh   = {rem_ff, div_bit};
      rem_diff = rem_sh - {1'b0, den_ff};
      div_ge   = (rem_sh >= {1'b0, den_ff});
      meas_q16 = {{2{req_measurement[MEAS_W-1]}}, req_measurement, 16'b0};
      est_wide = {{2{est_ff[DATA_W-1]}}, est_ff};
      res_ext  = {{17{res_ff[33]}}, res_ff};
      p_ext    = {17'b0, p_ff};
      corr     = acc1_ff[50:16];
      nx_sum   = {{4{est_ff[DATA_W-1]}}, est_ff} + {corr[34], corr};
      if (nx_sum[35:31] == 5'b00000 || nx_sum[35:31] == 5'b11111) begin
         nx_sat = nx_sum[31:0];
      end else if (nx_sum[35]) begin
         nx_sat = 32'h8000_0000;
      end else begin
         nx_sat = 32'h7FFF_FFFF;
      end
      out_free = !rsp_valid_ff || rsp_ready;
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      init_est_in  = init_est_ff;
      init_var_in  = init_var_ff;
      q_in         = q_ff;
      r_in         = r_ff;
      est_in       = est_ff;
      var_in       = var_ff;
      res_in       = res_ff;
      p_in         = p_ff;
      den_in       = den_ff;
      den_zero_in  = den_zero_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      ma_in        = ma_ff;
      mb_in        = mb_ff;
      acc1_in      = acc1_ff;
      acc2_in      = acc2_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;

      if (csr_wr_en) begin
         case (csr_index)
            REG_INIT_ESTIMATE: begin
               init_est_in = csr_wdata;
               est_in      = csr_wdata;
               var_in      = init_var_ff;
            end
            REG_INIT_VARIANCE: begin
               init_var_in = csr_wdata;
               est_in      = init_est_ff;
               var_in      = csr_wdata;
            end
            REG_PROCESS_NOISE: q_in = csr_wdata;
            REG_MEASURE_NOISE: r_in = csr_wdata;
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               res_in   = meas_q16 - est_wide;
               state_in = ST_PRED;
            end
         end
         ST_PRED: begin
            p_in     = p_sum[32] ? '1 : p_sum[31:0];
            state_in = ST_DEN;
         end
         ST_DEN: begin
            den_in      = den_sum[32] ? '1 : den_sum[31:0];
            den_zero_in = (den_sum == '0);
            rem_in      = {1'b0, p_ff[31:1]};
            quo_in      = '0;
            cnt_in      = '0;
            state_in    = ST_DIV;
         end
         ST_DIV: begin
            rem_in = div_ge ? rem_diff[31:0] : rem_sh[31:0];
            quo_in = {quo_ff[GAIN_W-2:0], div_ge && !den_zero_ff};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == LAST_STEP) begin
               ma_in    = {quo_ff[GAIN_W-2:0], div_ge && !den_zero_ff};
               mb_in    = GAIN_ONE - {quo_ff[GAIN_W-2:0], div_ge && !den_zero_ff};
               acc1_in  = '0;
               acc2_in  = '0;
               cnt_in   = '0;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            acc1_in = {acc1_ff[49:0], 1'b0} + (ma_ff[GAIN_W-1] ? res_ext : '0);
            acc2_in = {acc2_ff[47:0], 1'b0} + (mb_ff[GAIN_W-1] ? p_ext : '0);
            ma_in   = {ma_ff[GAIN_W-2:0], 1'b0};
            mb_in   = {mb_ff[GAIN_W-2:0], 1'b0};
            cnt_in  = cnt_ff + 1'b1;
            if (cnt_ff == LAST_STEP) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (out_free) begin
               est_in       = nx_sat;
               var_in       = acc2_ff[47:16];
               rsp_data_in  = nx_sat;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         init_est_ff  <= RST_INIT_ESTIMATE;
         init_var_ff  <= RST_INIT_VARIANCE;
         q_ff         <= RST_PROCESS_NOISE;
         r_ff         <= RST_MEASURE_NOISE;
         est_ff       <= RST_INIT_ESTIMATE;
         var_ff       <= RST_INIT_VARIANCE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         init_est_ff  <= init_est_in;
         init_var_ff  <= init_var_in;
         q_ff         <= q_in;
         r_ff         <= r_in;
         est_ff       <= est_in;
         var_ff       <= var_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      res_ff      <= res_in;
      p_ff        <= p_in;
      den_ff      <= den_in;
      den_zero_ff <= den_zero_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      ma_ff       <= ma_in;
      mb_ff       <= mb_in;
      acc1_ff     <= acc1_in;
      acc2_ff     <= acc2_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_ready             = (state_ff == ST_IDLE);
   assign rsp_valid             = rsp_valid_ff;
   assign rsp_filtered_estimate = rsp_data_ff;

endmodule

// File: rtl/skf_checker.sv
// ----------------------------------------------------------------------------
// skf_checker: port-level checks of the scalar kalman filter
// watches the request and response handshakes over time
// ----------------------------------------------------------------------------
module skf_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic signed [skf_pkg::DATA_W-1:0] rsp_filtered_estimate
);
   import skf_pkg::*;

   // stalled response word holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_filtered_estimate))
      else $error("stalled response word changed");

   // req_ready stays low through the prediction and denominator steps after a request word
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready ##1 !req_ready)
      else $error("request taken while busy");

   // a new response only comes out of the busy sequencer
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("response appeared without work in flight");

   // reset leaves the block idle with nothing pending
   assert property (@(posedge clock)
      reset |=> req_ready && !rsp_valid)
      else $error("block not idle after reset");

endmodule

bind scalar_kalman_filter_top skf_checker u_skf_checker (
   .clock                 (clock),
   .reset                 (reset),
   .req_valid             (req_valid),
   .req_ready             (req_ready),
   .rsp_valid             (rsp_valid),
   .rsp_ready             (rsp_ready),
   .rsp_filtered_estimate (rsp_filtered_estimate)
);
